/* hdl/prrs_pkg.sv */
// shared constants and types for the priority round-robin scheduler
package prrs_pkg;

  localparam int LEVELS      = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int POS_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W      = LVL_W + POS_W;
  localparam int SLOTS       = LEVELS * QUEUE_DEPTH;

  localparam logic [2:0] KIND_SCHEDULE    = 3'd0;
  localparam logic [2:0] KIND_YIELD       = 3'd1;
  localparam logic [2:0] KIND_BLOCK       = 3'd2;
  localparam logic [2:0] KIND_UNBLOCK     = 3'd3;
  localparam logic [2:0] KIND_UNBLOCK_ALL = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] task_id;
    logic [1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic       running_valid;
    logic [7:0] running_task;
    logic       queue_full;
  } rsp_t;

  // slot memory access from the sequencer
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [7:0]        wtask;
    logic              wblk;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] task_id;
    logic       blk;
  } mem_rsp_t;

  // map a level and a ring position to a flat slot address
  function automatic logic [SLOT_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [POS_W-1:0] pos);
    logic [SLOT_W+POS_W:0] a;
    a = (SLOT_W+POS_W+1)'(lvl) * (SLOT_W+POS_W+1)'(QUEUE_DEPTH)
        + (SLOT_W+POS_W+1)'(pos);
    return a[SLOT_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + POS_W'(1);
  endfunction

endpackage

/* hdl/prrs_if.sv */
// valid/ready channel carrying one payload
interface prrs_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/prrs_slot_mem.sv */
// slot memory holding task ids and blocked marks of every level
module prrs_slot_mem (
  input  logic              clk,
  input  prrs_pkg::mem_req_t mreq,
  output prrs_pkg::mem_rsp_t mrsp
);
  import prrs_pkg::*;

  logic [7:0] task_mem [SLOTS];
  logic       blk_mem  [SLOTS];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mreq.we) begin
      task_mem[mreq.waddr] <= mreq.wtask;
      blk_mem[mreq.waddr]  <= mreq.wblk;
    end
    mrsp.task_id <= task_mem[mreq.raddr];
    mrsp.blk     <= blk_mem[mreq.raddr];
  end
endmodule

/* hdl/prrs_seq.sv */
// sequencer that walks the slot memory one entry per step
module prrs_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  prrs_pkg::req_t     req,
  output logic               busy,
  output logic               done,
  output prrs_pkg::rsp_t     rsp,
  output prrs_pkg::mem_req_t mreq,
  input  prrs_pkg::mem_rsp_t mrsp
);
  import prrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_YIELD, S_PICK_RD, S_PICK_CHK, S_MARK_RD, S_MARK_CHK, S_ALL, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  head_r [LEVELS];
  logic [POS_W-1:0]  tail_r [LEVELS];
  logic [CNT_W-1:0]  cnt_r  [LEVELS];
  logic [POS_W-1:0]  head_nxt [LEVELS];
  logic [POS_W-1:0]  tail_nxt [LEVELS];
  logic [CNT_W-1:0]  cnt_nxt  [LEVELS];
  logic              run_v_r, run_v_nxt;
  logic [7:0]        run_id_r, run_id_nxt;
  logic [LVL_W-1:0]  run_lvl_r, run_lvl_nxt;
  logic              full_r, full_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [7:0]        id_r, id_nxt;
  logic              blk_r, blk_nxt;
  logic [LVL_W-1:0]  req_lvl;
  logic [POS_W-1:0]  mark_pos;
  logic              state_is_all_r;

  // saturate priority to the deepest level
  always_comb begin
    if (32'(req.priority_req) >= LEVELS) req_lvl = LVL_W'(LEVELS - 1);
    else req_lvl = LVL_W'(req.priority_req);
  end

  // ring position of the i-th entry in the scanned level
  always_comb begin
    logic [POS_W:0] s;
    s = (POS_W+1)'(head_r[lvl_r]) + (POS_W+1)'(i_r);
    if (32'(s) >= QUEUE_DEPTH) s = s - (POS_W+1)'(QUEUE_DEPTH);
    mark_pos = s[POS_W-1:0];
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign rsp.running_valid = run_v_r;
  assign rsp.running_task  = run_v_r ? run_id_r : 8'd0;
  assign rsp.queue_full    = full_r;

  // next state, queue pointers and memory commands
  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r; tail_nxt = tail_r; cnt_nxt = cnt_r;
    run_v_nxt = run_v_r; run_id_nxt = run_id_r; run_lvl_nxt = run_lvl_r;
    full_nxt = full_r; lvl_nxt = lvl_r; i_nxt = i_r;
    id_nxt = id_r; blk_nxt = blk_r;
    mreq = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          full_nxt = 1'b0;
          id_nxt = req.task_id;
          lvl_nxt = req_lvl;
          i_nxt = '0;
          state_nxt = S_DONE;
          unique case (req.kind)
            KIND_SCHEDULE: begin
              if (32'(cnt_r[req_lvl]) >= QUEUE_DEPTH) full_nxt = 1'b1;
              else begin
                mreq.we = 1'b1;
                mreq.waddr = slot_addr(req_lvl, tail_r[req_lvl]);
                mreq.wtask = req.task_id;
                mreq.wblk = 1'b0;
                tail_nxt[req_lvl] = pos_inc(tail_r[req_lvl]);
                cnt_nxt[req_lvl] = cnt_r[req_lvl] + CNT_W'(1);
              end
              if (!run_v_r) begin
                lvl_nxt = '0;
                state_nxt = S_PICK_RD;
              end
            end
            KIND_YIELD: state_nxt = S_YIELD;
            KIND_BLOCK: begin
              if (run_v_r && run_id_r == req.task_id) begin
                if (32'(cnt_r[req_lvl]) >= QUEUE_DEPTH) full_nxt = 1'b1;
                else begin
                  mreq.we = 1'b1;
                  mreq.waddr = slot_addr(req_lvl, tail_r[req_lvl]);
                  mreq.wtask = req.task_id;
                  mreq.wblk = 1'b1;
                  tail_nxt[req_lvl] = pos_inc(tail_r[req_lvl]);
                  cnt_nxt[req_lvl] = cnt_r[req_lvl] + CNT_W'(1);
                end
                run_v_nxt = 1'b0;
                run_id_nxt = '0;
                lvl_nxt = '0;
                state_nxt = S_PICK_RD;
              end else begin
                blk_nxt = 1'b1;
                state_nxt = S_MARK_RD;
              end
            end
            KIND_UNBLOCK: begin
              blk_nxt = 1'b0;
              state_nxt = S_MARK_RD;
            end
            KIND_UNBLOCK_ALL: begin
              lvl_nxt = '0;
              state_nxt = S_ALL;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // return the running task to its level
      S_YIELD: begin
        if (run_v_r) begin
          if (32'(cnt_r[run_lvl_r]) >= QUEUE_DEPTH) full_nxt = 1'b1;
          else begin
            mreq.we = 1'b1;
            mreq.waddr = slot_addr(run_lvl_r, tail_r[run_lvl_r]);
            mreq.wtask = run_id_r;
            mreq.wblk = 1'b0;
            tail_nxt[run_lvl_r] = pos_inc(tail_r[run_lvl_r]);
            cnt_nxt[run_lvl_r] = cnt_r[run_lvl_r] + CNT_W'(1);
          end
          run_v_nxt = 1'b0;
          run_id_nxt = '0;
        end
        lvl_nxt = '0;
        i_nxt = '0;
        state_nxt = S_PICK_RD;
      end
      // read the head entry of the current level, or move on once the level is scanned
      S_PICK_RD: begin
        if (i_r >= cnt_r[lvl_r]) begin
          i_nxt = '0;
          if (32'(lvl_r) == LEVELS - 1) state_nxt = S_DONE;
          else lvl_nxt = lvl_r + LVL_W'(1);
        end else begin
          mreq.raddr = slot_addr(lvl_r, head_r[lvl_r]);
          state_nxt = S_PICK_CHK;
        end
      end
      // take an unblocked head or rotate a blocked one to the tail
      S_PICK_CHK: begin
        head_nxt[lvl_r] = pos_inc(head_r[lvl_r]);
        if (!mrsp.blk) begin
          cnt_nxt[lvl_r] = cnt_r[lvl_r] - CNT_W'(1);
          run_v_nxt = 1'b1;
          run_id_nxt = mrsp.task_id;
          run_lvl_nxt = lvl_r;
          state_nxt = S_DONE;
        end else begin
          mreq.we = 1'b1;
          mreq.waddr = slot_addr(lvl_r, tail_r[lvl_r]);
          mreq.wtask = mrsp.task_id;
          mreq.wblk = 1'b1;
          tail_nxt[lvl_r] = pos_inc(tail_r[lvl_r]);
          i_nxt = i_r + CNT_W'(1);
          state_nxt = S_PICK_RD;
        end
      end
      // search the level for the first matching id
      S_MARK_RD: begin
        if (i_r >= cnt_r[lvl_r]) state_nxt = S_DONE;
        else begin
          mreq.raddr = slot_addr(lvl_r, mark_pos);
          state_nxt = S_MARK_CHK;
        end
      end
      S_MARK_CHK: begin
        if (mrsp.task_id == id_r) begin
          mreq.we = 1'b1;
          mreq.waddr = slot_addr(lvl_r, mark_pos);
          mreq.wtask = id_r;
          mreq.wblk = blk_r;
          state_nxt = S_DONE;
        end else begin
          i_nxt = i_r + CNT_W'(1);
          state_nxt = S_MARK_RD;
        end
      end
      // clear blocked marks, ids come back from a read first
      S_ALL: begin
        if (i_r >= cnt_r[lvl_r]) begin
          i_nxt = '0;
          if (32'(lvl_r) == LEVELS - 1) state_nxt = S_DONE;
          else lvl_nxt = lvl_r + LVL_W'(1);
        end else begin
          mreq.raddr = slot_addr(lvl_r, mark_pos);
          blk_nxt = 1'b1;
          state_nxt = S_MARK_CHK;
          id_nxt = id_r;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // unblock-all reuses the check step with a forced match
    if (state_r == S_MARK_CHK && blk_r && state_is_all_r) begin
      mreq.we = 1'b1;
      mreq.waddr = slot_addr(lvl_r, mark_pos);
      mreq.wtask = mrsp.task_id;
      mreq.wblk = 1'b0;
      i_nxt = i_r + CNT_W'(1);
      state_nxt = S_ALL;
    end
  end

  // state and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_v_r <= 1'b0;
      run_id_r <= '0;
      run_lvl_r <= '0;
      full_r <= 1'b0;
      state_is_all_r <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      run_v_r <= run_v_nxt;
      run_id_r <= run_id_nxt;
      run_lvl_r <= run_lvl_nxt;
      full_r <= full_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r <= cnt_nxt;
      if (state_r == S_IDLE) state_is_all_r <= start && (req.kind == KIND_UNBLOCK_ALL);
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    i_r <= i_nxt;
    id_r <= id_nxt;
    blk_r <= blk_nxt;
  end
endmodule

/* hdl/priority_round_robin_scheduler_unit.sv */
// Priority round-robin scheduler top level. One request is accepted when in_ready is high;
// the block then works alone and raises out_valid once its work is done, paced by one slot
// memory read per scanned entry. in_ready stays low until out_valid has been taken, so the
// block takes no new request before the last result is through. Each request yields one beat.
module priority_round_robin_scheduler_unit (
  input logic clk,
  input logic rst_n,
  prrs_if.sink   in_ch,
  prrs_if.source out_ch
);
  import prrs_pkg::*;

  prrs_pkg::mem_req_t mreq;
  prrs_pkg::mem_rsp_t mrsp;
  rsp_t               rsp;
  logic               busy, done, start;
  logic               out_v_r;
  rsp_t               out_d_r;

  assign in_ch.ready = !busy && !out_v_r;
  assign start = in_ch.valid && in_ch.ready;

  prrs_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .req(in_ch.data),
    .busy(busy), .done(done), .rsp(rsp), .mreq(mreq), .mrsp(mrsp)
  );

  prrs_slot_mem u_mem (.clk(clk), .mreq(mreq), .mrsp(mrsp));

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (done) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_d_r <= rsp;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  // handshake and result sanity checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("accept while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held");
  a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_d_r.running_valid) |-> (out_d_r.running_task == 8'd0))
    else $error("idle task nonzero");
endmodule
